// ----- sv/hspe_pkg.sv -----
// ----------------------------------------------------------------------------
// hspe_pkg
// shared types and constants of the heap shortest path engine
// ----------------------------------------------------------------------------
package hspe_pkg;

    localparam int MAX_NODES  = 1024;
    localparam int MAX_EDGES  = 4096;
    localparam int NODE_W     = $clog2(MAX_NODES);
    localparam int EDGE_AW    = $clog2(MAX_EDGES);
    localparam int LINK_W     = $clog2(MAX_EDGES + 1);
    localparam int CFG_W      = 11;
    localparam int DIST_W     = 30;
    localparam int KEY_W      = DIST_W + NODE_W;
    localparam int HEAP_DEPTH = MAX_EDGES + 1;
    localparam int HEAP_AW    = $clog2(HEAP_DEPTH);
    localparam int HSIZE_W    = $clog2(HEAP_DEPTH + 1);
    localparam int EDGE_DW    = NODE_W + DIST_W + LINK_W;
    localparam int DIST_DW    = DIST_W + 1;
    localparam int CNT_W      = NODE_W + 1;

    localparam logic [DIST_W-1:0] UNREACHED  = DIST_W'(32'h3f3f3f3f);
    localparam logic [LINK_W-1:0] EMPTY_LINK = LINK_W'(MAX_EDGES);

    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_FULL  = 2'd1;
    localparam logic [1:0] STATUS_RANGE = 2'd2;

    typedef enum logic [1:0] {
        OP_CLEAR = 2'd0,
        OP_ADD   = 2'd1,
        OP_RUN   = 2'd2,
        OP_READ  = 2'd3
    } op_t;

    typedef enum logic [4:0] {
        S_INIT,
        S_IDLE,
        S_CLEAR,
        S_ADD_RD,
        S_ADD_WR,
        S_RUN_INIT,
        S_RUN_SRC,
        S_POP,
        S_POP_TOP,
        S_POP_LAST,
        S_SD_A,
        S_SD_B,
        S_SD_C,
        S_USE,
        S_USE_B,
        S_USE_C,
        S_EDGE,
        S_EDGE_B,
        S_EDGE_C,
        S_PU_A,
        S_PU_B,
        S_READ,
        S_READ_B,
        S_DONE
    } state_t;

endpackage

// ----- sv/heap_shortest_path_engine.sv -----
// ----------------------------------------------------------------------------
// heap_shortest_path_engine
// single source shortest paths over a stored directed graph, binary min-heap
// ----------------------------------------------------------------------------
// Each input word is one command: clear the edge store, add an edge, run
// Dijkstra from a source, or read one node's distance from the last run; each
// gives one result word. One command is worked on at a time by a sequencer
// around four single-port-read memories (edge store, list heads, distances
// with settled flags, heap). After reset a clearing pass over all 1024 list
// heads and distances sets every list head empty and every distance
// unreached; no command is taken meanwhile. Clear empties one list head per
// cycle. A run first resets the distances of the nodes in use; then each heap
// pop takes a sift-down, each edge walked a relaxation and each improved
// distance a sift-up. The heap memory's single read port sets the pace.
// Unreached nodes read 1061109567.
// ----------------------------------------------------------------------------
module heap_shortest_path_engine (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [1:0]                    op,
    input  logic [hspe_pkg::NODE_W-1:0]   from_node,
    input  logic [hspe_pkg::NODE_W-1:0]   to_node,
    input  logic [hspe_pkg::DIST_W-1:0]   edge_weight,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [hspe_pkg::DIST_W-1:0]   distance,
    output logic                          reached,
    output logic [1:0]                    status,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [hspe_pkg::CFG_W-1:0]    cfg_data
);

    import hspe_pkg::*;

    // control state
    state_t                state_reg, state_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic [LINK_W-1:0]     edge_total_reg, edge_total_next;
    logic [CFG_W-1:0]      node_count_reg;
    logic [HSIZE_W-1:0]    heap_size_reg, heap_size_next;
    logic                  out_valid_reg, out_valid_next;

    // payload registers
    logic [NODE_W-1:0]     a_reg, a_next;
    logic [NODE_W-1:0]     b_reg, b_next;
    logic [DIST_W-1:0]     w_reg, w_next;
    logic [HEAP_AW-1:0]    hi_reg, hi_next;
    logic [HEAP_AW-1:0]    hc_reg, hc_next;
    logic [KEY_W-1:0]      child_reg, child_next;
    logic [KEY_W-1:0]      last_reg, last_next;
    logic [KEY_W-1:0]      key_reg, key_next;
    logic [NODE_W-1:0]     u_reg, u_next;
    logic [DIST_W-1:0]     du_reg, du_next;
    logic [LINK_W-1:0]     k_reg, k_next;
    logic [NODE_W-1:0]     t_reg, t_next;
    logic [DIST_W-1:0]     ew_reg, ew_next;
    logic [1:0]            st_reg, st_next;
    logic [DIST_W-1:0]     res_dist_reg, res_dist_next;
    logic                  res_reach_reg, res_reach_next;
    logic [DIST_W-1:0]     distance_reg, distance_next;
    logic                  reached_reg, reached_next;
    logic [1:0]            status_reg, status_next;

    // memory ports
    logic                  e_we;
    logic [EDGE_AW-1:0]    e_waddr, e_raddr;
    logic [EDGE_DW-1:0]    e_wdata, e_rdata;
    logic                  f_we;
    logic [NODE_W-1:0]     f_waddr, f_raddr;
    logic [LINK_W-1:0]     f_wdata, f_rdata;
    logic                  d_we;
    logic [NODE_W-1:0]     d_waddr, d_raddr;
    logic [DIST_DW-1:0]    d_wdata, d_rdata;
    logic                  h_we;
    logic [HEAP_AW-1:0]    h_waddr, h_raddr;
    logic [KEY_W-1:0]      h_wdata, h_rdata;

    // shared conditions
    logic [CFG_W-1:0]      n_eff;
    logic                  in_acc;
    logic                  a_in_bad, b_in_bad;
    logic                  full;
    logic                  out_free;
    logic [HEAP_AW:0]      sd_c;
    logic                  sd_has_l, sd_has_r, sd_pick_r, sd_stop;
    logic [KEY_W-1:0]      sd_val;
    logic [HEAP_AW-1:0]    sd_idx;
    logic [NODE_W-1:0]     e_t;
    logic [DIST_W-1:0]     e_w;
    logic [LINK_W-1:0]     e_nx;
    logic [DIST_W:0]       cand;
    logic                  relax;
    logic                  pu_stop;
    logic                  u_bad, t_bad, k_end, sweep_last, init_done;

    hspe_ram #(.WIDTH(EDGE_DW), .DEPTH(MAX_EDGES)) u_edge_ram (
        .clk   (clk),
        .we    (e_we),
        .waddr (e_waddr),
        .wdata (e_wdata),
        .raddr (e_raddr),
        .rdata (e_rdata)
    );

    hspe_ram #(.WIDTH(LINK_W), .DEPTH(MAX_NODES)) u_head_ram (
        .clk   (clk),
        .we    (f_we),
        .waddr (f_waddr),
        .wdata (f_wdata),
        .raddr (f_raddr),
        .rdata (f_rdata)
    );

    // distance with settled flag on top
    hspe_ram #(.WIDTH(DIST_DW), .DEPTH(MAX_NODES)) u_dist_ram (
        .clk   (clk),
        .we    (d_we),
        .waddr (d_waddr),
        .wdata (d_wdata),
        .raddr (d_raddr),
        .rdata (d_rdata)
    );

    // heap keys: distance above node, so key order is distance then node
    hspe_ram #(.WIDTH(KEY_W), .DEPTH(HEAP_DEPTH)) u_heap_ram (
        .clk   (clk),
        .we    (h_we),
        .waddr (h_waddr),
        .wdata (h_wdata),
        .raddr (h_raddr),
        .rdata (h_rdata)
    );

    // handshakes
    assign in_ready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign in_acc    = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign distance  = distance_reg;
    assign reached   = reached_reg;
    assign status    = status_reg;
    assign out_free  = !out_valid_reg || out_ready;

    // node count capped at the store size
    assign n_eff    = (node_count_reg > CFG_W'(MAX_NODES)) ? CFG_W'(MAX_NODES) : node_count_reg;
    assign a_in_bad = {1'b0, from_node} >= n_eff;
    assign b_in_bad = {1'b0, to_node} >= n_eff;
    assign full     = edge_total_reg >= LINK_W'(MAX_EDGES);

    // sweep end: last list head, or last node in use for run set-up
    assign sweep_last = cnt_reg == CNT_W'(MAX_NODES - 1);
    assign init_done  = cnt_reg >= n_eff;

    // sift-down child selection
    assign sd_c      = {hi_reg, 1'b1};
    assign sd_has_l  = sd_c < {1'b0, heap_size_reg};
    assign sd_has_r  = ({1'b0, hc_reg} + (HEAP_AW + 1)'(1)) < {1'b0, heap_size_reg};
    assign sd_pick_r = (state_reg == S_SD_C) && (h_rdata < child_reg);
    assign sd_val    = (state_reg == S_SD_C) ? (sd_pick_r ? h_rdata : child_reg) : h_rdata;
    assign sd_idx    = sd_pick_r ? (hc_reg + HEAP_AW'(1)) : hc_reg;
    assign sd_stop   = last_reg <= sd_val;

    // edge walk and relaxation
    assign e_t     = e_rdata[EDGE_DW-1 -: NODE_W];
    assign e_w     = e_rdata[LINK_W +: DIST_W];
    assign e_nx    = e_rdata[LINK_W-1:0];
    assign u_bad   = {1'b0, u_reg} >= n_eff;
    assign t_bad   = {1'b0, e_t} >= n_eff;
    assign k_end   = k_reg >= edge_total_reg;
    assign cand    = {1'b0, du_reg} + {1'b0, ew_reg};
    assign relax   = {1'b0, d_rdata[DIST_W-1:0]} > cand;
    assign pu_stop = h_rdata <= key_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_INIT:     if (sweep_last) state_next = S_IDLE;
            S_IDLE:
            begin
                if (in_acc)
                begin
                    case (op_t'(op))
                        OP_CLEAR: state_next = S_CLEAR;
                        OP_ADD:   state_next = (a_in_bad || b_in_bad || full) ? S_DONE : S_ADD_RD;
                        OP_RUN:   state_next = a_in_bad ? S_DONE : S_RUN_INIT;
                        OP_READ:  state_next = a_in_bad ? S_DONE : S_READ;
                        default:  state_next = S_DONE;
                    endcase
                end
            end
            S_CLEAR:    if (sweep_last) state_next = S_DONE;
            S_ADD_RD:   state_next = S_ADD_WR;
            S_ADD_WR:   state_next = S_DONE;
            S_RUN_INIT: if (init_done) state_next = S_RUN_SRC;
            S_RUN_SRC:  state_next = S_POP;
            S_POP:      state_next = (heap_size_reg == '0) ? S_DONE : S_POP_TOP;
            S_POP_TOP:  state_next = S_POP_LAST;
            S_POP_LAST: state_next = S_SD_A;
            S_SD_A:     state_next = sd_has_l ? S_SD_B : S_USE;
            S_SD_B:
            begin
                if (sd_has_r)
                    state_next = S_SD_C;
                else
                    state_next = sd_stop ? S_USE : S_SD_A;
            end
            S_SD_C:     state_next = sd_stop ? S_USE : S_SD_A;
            S_USE:      state_next = u_bad ? S_POP : S_USE_B;
            S_USE_B:    state_next = d_rdata[DIST_W] ? S_POP : S_USE_C;
            S_USE_C:    state_next = S_EDGE;
            S_EDGE:     state_next = k_end ? S_POP : S_EDGE_B;
            S_EDGE_B:   state_next = t_bad ? S_EDGE : S_EDGE_C;
            S_EDGE_C:   state_next = relax ? S_PU_A : S_EDGE;
            S_PU_A:     state_next = (hi_reg == '0) ? S_EDGE : S_PU_B;
            S_PU_B:     state_next = pu_stop ? S_EDGE : S_PU_A;
            S_READ:     state_next = S_READ_B;
            S_READ_B:   state_next = S_DONE;
            S_DONE:     if (out_free) state_next = S_IDLE;
            default:    state_next = S_INIT;
        endcase
    end

    // datapath and memory controls
    always_comb
    begin
        cnt_next        = cnt_reg;
        edge_total_next = edge_total_reg;
        heap_size_next  = heap_size_reg;
        a_next          = a_reg;
        b_next          = b_reg;
        w_next          = w_reg;
        hi_next         = hi_reg;
        hc_next         = hc_reg;
        child_next      = child_reg;
        last_next       = last_reg;
        key_next        = key_reg;
        u_next          = u_reg;
        du_next         = du_reg;
        k_next          = k_reg;
        t_next          = t_reg;
        ew_next         = ew_reg;
        st_next         = st_reg;
        res_dist_next   = res_dist_reg;
        res_reach_next  = res_reach_reg;
        distance_next   = distance_reg;
        reached_next    = reached_reg;
        status_next     = status_reg;
        out_valid_next  = out_valid_reg;

        e_we    = 1'b0;
        e_waddr = edge_total_reg[EDGE_AW-1:0];
        e_wdata = {b_reg, w_reg, f_rdata};
        e_raddr = k_reg[EDGE_AW-1:0];
        f_we    = 1'b0;
        f_waddr = cnt_reg[NODE_W-1:0];
        f_wdata = EMPTY_LINK;
        f_raddr = a_reg;
        d_we    = 1'b0;
        d_waddr = cnt_reg[NODE_W-1:0];
        d_wdata = {1'b0, UNREACHED};
        d_raddr = a_reg;
        h_we    = 1'b0;
        h_waddr = hi_reg;
        h_wdata = last_reg;
        h_raddr = '0;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_INIT:
            begin
                f_we     = 1'b1;
                d_we     = 1'b1;
                cnt_next = cnt_reg + CNT_W'(1);
            end
            S_IDLE:
            begin
                if (in_acc)
                begin
                    a_next         = from_node;
                    b_next         = to_node;
                    w_next         = edge_weight;
                    cnt_next       = '0;
                    res_dist_next  = '0;
                    res_reach_next = 1'b0;
                    st_next        = STATUS_OK;
                    case (op_t'(op))
                        OP_CLEAR: edge_total_next = '0;
                        OP_ADD:
                        begin
                            if (a_in_bad || b_in_bad)
                                st_next = STATUS_RANGE;
                            else if (full)
                                st_next = STATUS_FULL;
                        end
                        OP_RUN, OP_READ:
                        begin
                            if (a_in_bad)
                                st_next = STATUS_RANGE;
                        end
                        default: st_next = STATUS_OK;
                    endcase
                end
            end
            S_CLEAR:
            begin
                f_we     = 1'b1;
                cnt_next = cnt_reg + CNT_W'(1);
            end
            S_ADD_RD:
            begin
                f_raddr = a_reg;
            end
            S_ADD_WR:
            begin
                // new edge goes to the front of the tail's list
                e_we            = 1'b1;
                f_we            = 1'b1;
                f_waddr         = a_reg;
                f_wdata         = edge_total_reg;
                edge_total_next = edge_total_reg + LINK_W'(1);
            end
            S_RUN_INIT:
            begin
                if (!init_done)
                begin
                    d_we     = 1'b1;
                    cnt_next = cnt_reg + CNT_W'(1);
                end
            end
            S_RUN_SRC:
            begin
                d_we           = 1'b1;
                d_waddr        = a_reg;
                d_wdata        = '0;
                h_we           = 1'b1;
                h_waddr        = '0;
                h_wdata        = {{DIST_W{1'b0}}, a_reg};
                heap_size_next = HSIZE_W'(1);
            end
            S_POP:
            begin
                h_raddr = '0;
            end
            S_POP_TOP:
            begin
                u_next         = h_rdata[NODE_W-1:0];
                h_raddr        = HEAP_AW'(heap_size_reg - HSIZE_W'(1));
                heap_size_next = heap_size_reg - HSIZE_W'(1);
            end
            S_POP_LAST:
            begin
                last_next = h_rdata;
                hi_next   = '0;
            end
            S_SD_A:
            begin
                if (sd_has_l)
                begin
                    h_raddr = sd_c[HEAP_AW-1:0];
                    hc_next = sd_c[HEAP_AW-1:0];
                end
                else
                begin
                    h_we = 1'b1;
                end
            end
            S_SD_B, S_SD_C:
            begin
                if (state_reg == S_SD_B && sd_has_r)
                begin
                    child_next = h_rdata;
                    h_raddr    = hc_reg + HEAP_AW'(1);
                end
                else if (sd_stop)
                begin
                    h_we = 1'b1;
                end
                else
                begin
                    // smaller child moves up a level
                    h_we    = 1'b1;
                    h_wdata = sd_val;
                    hi_next = sd_idx;
                end
            end
            S_USE:
            begin
                d_raddr = u_reg;
            end
            S_USE_B:
            begin
                if (!d_rdata[DIST_W])
                begin
                    d_we    = 1'b1;
                    d_waddr = u_reg;
                    d_wdata = {1'b1, d_rdata[DIST_W-1:0]};
                    du_next = d_rdata[DIST_W-1:0];
                    f_raddr = u_reg;
                end
            end
            S_USE_C:
            begin
                k_next = f_rdata;
            end
            S_EDGE:
            begin
                e_raddr = k_reg[EDGE_AW-1:0];
            end
            S_EDGE_B:
            begin
                t_next  = e_t;
                ew_next = e_w;
                k_next  = e_nx;
                d_raddr = e_t;
            end
            S_EDGE_C:
            begin
                if (relax)
                begin
                    d_we           = 1'b1;
                    d_waddr        = t_reg;
                    d_wdata        = {d_rdata[DIST_W], cand[DIST_W-1:0]};
                    key_next       = {cand[DIST_W-1:0], t_reg};
                    hi_next        = HEAP_AW'(heap_size_reg);
                    heap_size_next = heap_size_reg + HSIZE_W'(1);
                end
            end
            S_PU_A:
            begin
                if (hi_reg == '0)
                begin
                    h_we    = 1'b1;
                    h_waddr = '0;
                    h_wdata = key_reg;
                end
                else
                begin
                    h_raddr = (hi_reg - HEAP_AW'(1)) >> 1;
                    hc_next = (hi_reg - HEAP_AW'(1)) >> 1;
                end
            end
            S_PU_B:
            begin
                h_we = 1'b1;
                if (pu_stop)
                begin
                    h_wdata = key_reg;
                end
                else
                begin
                    // parent moves down a level
                    h_wdata = h_rdata;
                    hi_next = hc_reg;
                end
            end
            S_READ:
            begin
                d_raddr = a_reg;
            end
            S_READ_B:
            begin
                res_dist_next  = d_rdata[DIST_W-1:0];
                res_reach_next = d_rdata[DIST_W-1:0] < UNREACHED;
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    distance_next  = res_dist_reg;
                    reached_next   = res_reach_reg;
                    status_next    = st_reg;
                    heap_size_next = '0;
                end
            end
            default:
            begin
                cnt_next = cnt_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_INIT;
            cnt_reg        <= '0;
            edge_total_reg <= '0;
            node_count_reg <= CFG_W'(MAX_NODES);
            heap_size_reg  <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            cnt_reg        <= cnt_next;
            edge_total_reg <= edge_total_next;
            heap_size_reg  <= heap_size_next;
            out_valid_reg  <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                node_count_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg         <= a_next;
        b_reg         <= b_next;
        w_reg         <= w_next;
        hi_reg        <= hi_next;
        hc_reg        <= hc_next;
        child_reg     <= child_next;
        last_reg      <= last_next;
        key_reg       <= key_next;
        u_reg         <= u_next;
        du_reg        <= du_next;
        k_reg         <= k_next;
        t_reg         <= t_next;
        ew_reg        <= ew_next;
        st_reg        <= st_next;
        res_dist_reg  <= res_dist_next;
        res_reach_reg <= res_reach_next;
        distance_reg  <= distance_next;
        reached_reg   <= reached_next;
        status_reg    <= status_next;
    end

endmodule

// ----- sv/hspe_ram.sv -----
// ----------------------------------------------------------------------------
// hspe_ram
// generic simple dual port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
module hspe_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- verif/hspe_checker.sv -----
// ----------------------------------------------------------------------------
// hspe_checker
// watches command, result and node count channels, predicts each result word
// ----------------------------------------------------------------------------
module hspe_checker
    import hspe_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              in_ready,
    input  logic [1:0]        op,
    input  logic [NODE_W-1:0] from_node,
    input  logic [NODE_W-1:0] to_node,
    input  logic [DIST_W-1:0] edge_weight,
    input  logic              out_valid,
    input  logic              out_ready,
    input  logic [DIST_W-1:0] distance,
    input  logic              reached,
    input  logic [1:0]        status,
    input  logic              cfg_valid,
    input  logic              cfg_ready,
    input  logic [CFG_W-1:0]  cfg_data,
    output int                errors,
    output int                pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [DIST_W-1:0] dval;
        logic              hit;
        logic [1:0]        code;
    } result_t;

    result_t           awaited[$];
    logic [CFG_W-1:0]  node_limit;
    int                edge_count;
    int                list_head[MAX_NODES];
    int                list_link[MAX_EDGES];
    logic [NODE_W-1:0] edge_dst[MAX_EDGES];
    logic [DIST_W-1:0] edge_len[MAX_EDGES];
    logic [DIST_W-1:0] shortest[MAX_NODES];
    bit                fixed[MAX_NODES];

    task automatic report_mismatch(string what, longint got, longint want);
        $display("%0t mismatch %s: got %0d want %0d", $realtime, what, got, want);
        errors++;
    endtask

    task automatic clear_store();
        for (int i = 0; i < MAX_NODES; i++)
            list_head[i] = -1;
        edge_count = 0;
    endtask

    // plain Dijkstra by linear selection, same distances as a heap walk
    task automatic settle_paths(int src, int n);
        int u;
        int k;
        logic [DIST_W:0] cand;
        for (int i = 0; i < n; i++)
        begin
            shortest[i] = UNREACHED;
            fixed[i] = 0;
        end
        shortest[src] = '0;
        while (1)
        begin
            u = -1;
            for (int i = 0; i < n; i++)
                if (!fixed[i] && shortest[i] < UNREACHED
                    && (u < 0 || shortest[i] < shortest[u]))
                    u = i;
            if (u < 0)
                break;
            fixed[u] = 1;
            k = list_head[u];
            while (k >= 0)
            begin
                // edges into nodes beyond the count are skipped
                if (int'(edge_dst[k]) < n)
                begin
                    cand = {1'b0, shortest[u]} + edge_len[k];
                    if (cand < {1'b0, shortest[edge_dst[k]]})
                        shortest[edge_dst[k]] = cand[DIST_W-1:0];
                end
                k = list_link[k];
            end
        end
    endtask

    task automatic predict_command(output result_t r);
        int n;
        n = (node_limit > MAX_NODES) ? MAX_NODES : int'(node_limit);
        r = '0;
        r.code = STATUS_OK;
        case (op_t'(op))
            OP_CLEAR: clear_store();
            OP_ADD:
            begin
                // range is checked before fullness
                if (int'(from_node) >= n || int'(to_node) >= n)
                    r.code = STATUS_RANGE;
                else if (edge_count >= MAX_EDGES)
                    r.code = STATUS_FULL;
                else
                begin
                    edge_dst[edge_count] = to_node;
                    edge_len[edge_count] = edge_weight;
                    list_link[edge_count] = list_head[from_node];
                    list_head[from_node] = edge_count;
                    edge_count++;
                end
            end
            OP_RUN:
            begin
                if (int'(from_node) >= n)
                    r.code = STATUS_RANGE;
                else
                    settle_paths(from_node, n);
            end
            default:
            begin
                if (int'(from_node) >= n)
                    r.code = STATUS_RANGE;
                else
                begin
                    r.dval = shortest[from_node];
                    r.hit = shortest[from_node] < UNREACHED;
                end
            end
        endcase
    endtask

    initial
    begin
        errors = 0;
        pending = 0;
        node_limit = CFG_W'(MAX_NODES);
        clear_store();
        for (int i = 0; i < MAX_NODES; i++)
            shortest[i] = UNREACHED;
    end

    // sampled at the falling edge: a word seen here moves at the next rise
    always @(negedge clk)
    begin
        result_t want;
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
                node_limit = cfg_data;
            if (in_valid && in_ready)
            begin
                predict_command(want);
                awaited = {awaited, want};
            end
            if (out_valid && out_ready)
            begin
                if (awaited.size() == 0)
                    report_mismatch("unexpected result word", status, -1);
                else
                begin
                    want = awaited.pop_front();
                    if (distance !== want.dval)
                        report_mismatch("distance", distance, want.dval);
                    if (reached !== want.hit)
                        report_mismatch("reached", reached, want.hit);
                    if (status !== want.code)
                        report_mismatch("status", status, want.code);
                end
            end
            pending = awaited.size();
        end
    end

endmodule

// ----- verif/heap_shortest_path_engine_tb.sv -----
// ----------------------------------------------------------------------------
// heap_shortest_path_engine_tb
// clear, add, run and read commands under several node counts, random idling
// ----------------------------------------------------------------------------
module heap_shortest_path_engine_tb;
    import hspe_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    logic              clk;
    logic              rst_n;
    logic              in_valid;
    logic              in_ready;
    logic [1:0]        op;
    logic [NODE_W-1:0] from_node;
    logic [NODE_W-1:0] to_node;
    logic [DIST_W-1:0] edge_weight;
    logic              out_valid;
    logic              out_ready;
    logic [DIST_W-1:0] distance;
    logic              reached;
    logic [1:0]        status;
    logic              cfg_valid;
    logic              cfg_ready;
    logic [CFG_W-1:0]  cfg_data;
    int                errors;
    int                pending;
    bit                calm;    // no idling on either side while set

    heap_shortest_path_engine dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .op          (op),
        .from_node   (from_node),
        .to_node     (to_node),
        .edge_weight (edge_weight),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .distance    (distance),
        .reached     (reached),
        .status      (status),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data)
    );

    hspe_checker path_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .op          (op),
        .from_node   (from_node),
        .to_node     (to_node),
        .edge_weight (edge_weight),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .distance    (distance),
        .reached     (reached),
        .status      (status),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data),
        .errors      (errors),
        .pending     (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // result side stalls with a chance of about 17 in a hundred
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
            out_ready <= calm || ($urandom_range(99) >= 17);
    end

    // one command word; valid stays up across back-to-back words
    task automatic push_word(op_t o, int a, int b, logic [DIST_W-1:0] w);
        bit taken;
        if (!calm)
            while ($urandom_range(99) < 17)
            begin
                in_valid <= 1'b0;
                @(posedge clk);
            end
        in_valid <= 1'b1;
        op <= o;
        from_node <= NODE_W'(a);
        to_node <= NODE_W'(b);
        edge_weight <= w;
        do
        begin
            @(negedge clk);
            taken = in_ready;
            @(posedge clk);
        end
        while (!taken);
    endtask

    // node count only changes once every result is back and the engine is idle
    task automatic write_limit(int v);
        bit taken;
        in_valid <= 1'b0;
        wait (pending == 0);
        repeat (12) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= CFG_W'(v);
        do
        begin
            @(negedge clk);
            taken = cfg_ready;
            @(posedge clk);
        end
        while (!taken);
        cfg_valid <= 1'b0;
    endtask

    // mix of short, full width, near unreached and zero lengths
    function automatic logic [DIST_W-1:0] pick_weight();
        case ($urandom_range(3))
            0: return DIST_W'($urandom_range(0, 100));
            1: return DIST_W'($urandom);
            2: return UNREACHED - DIST_W'($urandom_range(0, 3));
            default: return '0;
        endcase
    endfunction

    // mostly well-formed graph building and queries, a little noise
    task automatic random_phase(int n, int count);
        int r;
        push_word(OP_CLEAR, $urandom, $urandom, DIST_W'($urandom));
        for (int i = 1; i < count; i++)
        begin
            r = $urandom_range(99);
            if (r < 45)
                push_word(OP_ADD, $urandom_range(n - 1), $urandom_range(n - 1),
                          pick_weight());
            else if (r < 52)
                push_word(OP_ADD, $urandom, $urandom, DIST_W'($urandom));
            else if (r < 62)
                push_word(OP_RUN, $urandom_range(n - 1), $urandom, DIST_W'($urandom));
            else if (r < 65)
                push_word(OP_RUN, $urandom, $urandom, DIST_W'($urandom));
            else if (r < 92)
                push_word(OP_READ, $urandom_range(n - 1), $urandom, DIST_W'($urandom));
            else if (r < 97)
                push_word(OP_READ, $urandom, $urandom, DIST_W'($urandom));
            else
                push_word(OP_CLEAR, $urandom, $urandom, DIST_W'($urandom));
        end
    endtask

    initial
    begin
        calm = 1'b0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        op = OP_CLEAR;
        from_node = '0;
        to_node = '0;
        edge_weight = '0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // directed: small graph with extreme lengths
        write_limit(8);
        push_word(OP_CLEAR, 0, 0, '0);
        push_word(OP_ADD, 0, 1, '0);
        push_word(OP_ADD, 1, 2, '1);
        push_word(OP_ADD, 0, 3, UNREACHED - 1);
        push_word(OP_ADD, 3, 4, 1);          // path reaching unreached value
        push_word(OP_ADD, 0, 5, 5);
        push_word(OP_ADD, 5, 6, 7);
        push_word(OP_ADD, 8, 1, 3);          // tail out of range
        push_word(OP_ADD, 1, 1023, 3);       // head out of range
        push_word(OP_RUN, 0, 0, '0);
        for (int i = 0; i < 8; i++)
            push_word(OP_READ, i, 0, '0);
        push_word(OP_READ, 8, 0, '0);
        push_word(OP_RUN, 1023, 0, '0);
        push_word(OP_CLEAR, 0, 0, '0);
        push_word(OP_READ, 6, 0, '0);        // distance survives a clear
        push_word(OP_RUN, 0, 0, '0);
        push_word(OP_READ, 6, 0, '0);

        // edge into a node that drops out of range
        push_word(OP_ADD, 0, 7, 2);
        push_word(OP_ADD, 7, 1, 1);
        push_word(OP_ADD, 0, 1, 9);
        write_limit(5);
        push_word(OP_RUN, 0, 0, '0);
        push_word(OP_READ, 1, 0, '0);
        write_limit(8);
        push_word(OP_READ, 7, 0, '0);        // left alone by the last run

        // zero node count: every node is out of range
        write_limit(0);
        push_word(OP_CLEAR, 0, 0, '0);
        push_word(OP_ADD, 0, 0, 1);
        push_word(OP_RUN, 0, 0, '0);
        push_word(OP_READ, 0, 0, '0);

        // count above the maximum is limited to it
        write_limit(2047);
        push_word(OP_ADD, 1023, 0, 4);
        push_word(OP_RUN, 1023, 0, '0);
        push_word(OP_READ, 0, 0, '0);
        push_word(OP_READ, 1023, 0, '0);
        push_word(OP_READ, 512, 0, '0);

        // random graphs, one node count per phase
        for (int p = 0; p < 10; p++)
        begin
            write_limit(p == 3 ? 1 : $urandom_range(2, 48));
            calm = (p == 5);
            random_phase(p == 3 ? 1 : int'(path_check.node_limit), 48);
            calm = 1'b0;
        end

        // full node count with a sparse graph
        write_limit(1024);
        push_word(OP_CLEAR, 0, 0, '0);
        for (int i = 0; i < 20; i++)
            push_word(OP_ADD, $urandom, $urandom, pick_weight());
        push_word(OP_ADD, 5, 1023, 6);
        push_word(OP_RUN, 5, 0, '0);
        push_word(OP_READ, 1023, 0, '0);
        for (int i = 0; i < 12; i++)
            push_word(OP_READ, $urandom, 0, '0);

        in_valid <= 1'b0;
        wait (pending == 0);
        repeat (40) @(posedge clk);
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    // watchdog, well above the slowest correct run
    initial
    begin
        #40ms;
        $display("DONE: errors detected");
        $finish;
    end

endmodule
